### hw/rtl/ltcm_pkg.sv
// ============================================================================
// ltcm_pkg : shared definitions for the line tile coverage marker
// Grid geometry, configuration indexes, operation codes, beat payload types,
// divider request/response types and the sequencer state encoding.
// ============================================================================
package ltcm_pkg;

  // Grid geometry and the derived widths.
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int MAP_DEPTH = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  // Field and datapath widths.
  localparam int COORD_W    = 16;
  localparam int IDX_W      = COORD_W + 1;
  localparam int QIDX_W     = 6;
  localparam int DIVIDEND_W = 2 * COORD_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LONG  = DIV_CNT_W'(DIVIDEND_W);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SHORT = DIV_CNT_W'(COORD_W);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 1'b1;
  localparam logic [COORD_W-1:0]   TILE_SIZE_RESET = 16'd256;

  // Operation codes.
  localparam logic OP_MARK_LINE = 1'b0;
  localparam logic OP_QUERY     = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [QIDX_W-1:0]  query_col;
    logic [QIDX_W-1:0]  query_row;
  } in_item_t;

  typedef struct packed {
    logic marked;
    logic out_of_grid;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic                  long_op;
    logic [DIVIDEND_W-1:0] dividend;
    logic [COORD_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [COORD_W-1:0] quotient;
    logic [COORD_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QRD,
    ST_QFIN,
    ST_SC,
    ST_SR,
    ST_EC,
    ST_ER,
    ST_VLO,
    ST_VWALK,
    ST_ALO,
    ST_ACHK,
    ST_ADIV,
    ST_BIDX,
    ST_FIN
  } ltcm_state_t;

endpackage

### hw/rtl/ltcm_divider.sv
// ============================================================================
// ltcm_divider : shared restoring divider
// Unsigned divide of a 16- or 32-bit dividend by a 16-bit divisor, one
// quotient bit per cycle. The quotient is known to fit in 16 bits.
// ============================================================================
module ltcm_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  ltcm_pkg::div_req_t req,
  output ltcm_pkg::div_rsp_t rsp
);
  import ltcm_pkg::*;

  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [COORD_W-1:0]    rem_r, rem_nxt;
  logic [COORD_W-1:0]    den_r, den_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COORD_W:0]      shifted;
  logic [COORD_W:0]      trial;
  logic                  fits;

  always_comb begin
    shifted = {rem_r, dq_r[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, den_r};
    fits    = (shifted >= {1'b0, den_r});
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (req.start) begin
      // A short divide places its 16-bit dividend at the top of the shifter.
      dq_nxt  = req.long_op ? req.dividend
                            : {req.dividend[COORD_W-1:0], {(DIVIDEND_W-COORD_W){1'b0}}};
      rem_nxt = '0;
      den_nxt = req.divisor;
      cnt_nxt = req.long_op ? DIV_STEPS_LONG : DIV_STEPS_SHORT;
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? trial[COORD_W-1:0] : shifted[COORD_W-1:0];
      dq_nxt  = {dq_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy      = (cnt_r != '0);
  assign rsp.quotient  = dq_r[COORD_W-1:0];
  assign rsp.remainder = rem_r;

endmodule

### hw/rtl/line_tile_coverage_marker_unit.sv
// ============================================================================
// line_tile_coverage_marker_unit : grid line traversal tile marker
// Keeps a bitmap of grid tiles, marks the tiles a segment passes through at
// its endpoints and grid line crossings, and answers single tile queries.
// ============================================================================
// One beat is worked on at a time; in_ready is high only while the sequencer
// is idle, and a finished result waits in the output register so that the
// next beat can be taken before the result is collected. After reset the
// bitmap is cleared one tile per cycle; no beat is taken during that pass,
// though configuration writes are. A query reads its tile in ST_QRD, forms
// the result in ST_QFIN and hands it to the output register in ST_FIN.
// A mark-line beat is paced by the single shared divider, which produces one
// quotient bit per cycle: each endpoint coordinate is divided by the tile
// size, every vertical or horizontal grid line crossed costs a range check,
// an interpolation divide of a 32-bit product and a 16-bit tile index
// divide, and a vertical segment is walked at one tile-height step per cycle
// after one divide. A sloped segment also has a second pass over the
// horizontal grid lines.
// ============================================================================
module line_tile_coverage_marker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ltcm_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ltcm_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [ltcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ltcm_pkg::COORD_W-1:0]      cfg_wdata
);
  import ltcm_pkg::*;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  ltcm_state_t         state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [COORD_W-1:0]  tile_w_r, tile_w_nxt;
  logic [COORD_W-1:0]  tile_h_r, tile_h_nxt;
  logic [COORD_W-1:0]  col_s_r, col_s_nxt;
  logic [COORD_W-1:0]  col_e_r, col_e_nxt;
  logic                pass_r, pass_nxt;
  logic [IDX_W-1:0]    la_r, la_nxt;
  logic [IDX_W-1:0]    li_r, li_nxt;
  logic                neg_r, neg_nxt;
  logic                res_marked_r, res_marked_nxt;
  logic                res_oog_r, res_oog_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic                rd_data_r;

  // The tile bitmap, one bit per tile, addressed column-major.
  logic                tile_mem [0:MAP_DEPTH-1];

  // --------------------------------------------------------------------------
  // Combinational signals
  // --------------------------------------------------------------------------
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [COORD_W-1:0]  eff_w, eff_h;
  logic [COORD_W-1:0]  min_x, max_x, min_y, max_y;
  logic [COORD_W-1:0]  a_s, a_e, b_s, b_e;
  logic [COORD_W-1:0]  step_a, step_b, min_a, max_a;
  logic [COORD_W-1:0]  a_mag, b_mag, la_mag;
  logic                la_lt_as;
  logic                la_ok;
  logic                cross_neg;
  logic [DIVIDEND_W-1:0] cross_prod;
  logic [COORD_W-1:0]  b_val;
  logic                in_accept;
  logic                q_in_grid;
  logic [ADDR_W-1:0]   q_addr;
  logic                mk_en;
  logic [IDX_W-1:0]    mk_col, mk_row;
  logic                mk_in_grid;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic                mem_wdata;
  logic                rd_en;

  function automatic logic [ADDR_W-1:0] tile_addr(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    tile_addr = ADDR_W'(32'(col) * GRID_ROWS + 32'(row));
  endfunction

  ltcm_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // A tile size of zero behaves as a size of one.
  assign eff_w = (tile_w_r == '0) ? COORD_W'(1) : tile_w_r;
  assign eff_h = (tile_h_r == '0) ? COORD_W'(1) : tile_h_r;

  assign min_x = (item_r.start_x < item_r.end_x) ? item_r.start_x : item_r.end_x;
  assign max_x = (item_r.start_x < item_r.end_x) ? item_r.end_x   : item_r.start_x;
  assign min_y = (item_r.start_y < item_r.end_y) ? item_r.start_y : item_r.end_y;
  assign max_y = (item_r.start_y < item_r.end_y) ? item_r.end_y   : item_r.start_y;

  // The "a" axis is the one whose grid lines are being crossed: x in the
  // first pass, y in the second pass and in the vertical walk.
  assign a_s    = pass_r ? item_r.start_y : item_r.start_x;
  assign a_e    = pass_r ? item_r.end_y   : item_r.end_x;
  assign b_s    = pass_r ? item_r.start_x : item_r.start_y;
  assign b_e    = pass_r ? item_r.end_x   : item_r.end_y;
  assign step_a = pass_r ? eff_h : eff_w;
  assign step_b = pass_r ? eff_w : eff_h;
  assign min_a  = pass_r ? min_y : min_x;
  assign max_a  = pass_r ? max_y : max_x;

  assign a_mag    = (a_e < a_s) ? (a_s - a_e) : (a_e - a_s);
  assign b_mag    = (b_e < b_s) ? (b_s - b_e) : (b_e - b_s);
  assign la_lt_as = (la_r < {1'b0, a_s});
  assign la_mag   = la_lt_as ? COORD_W'({1'b0, a_s} - la_r) : COORD_W'(la_r - {1'b0, a_s});
  assign la_ok    = (la_r <= {1'b0, max_a});

  // Interpolation works on magnitudes; the quotient is truncated towards
  // zero and the sign is applied afterwards.
  assign cross_prod = {{(DIVIDEND_W-COORD_W){1'b0}}, b_mag} *
                      {{(DIVIDEND_W-COORD_W){1'b0}}, la_mag};
  assign cross_neg  = (b_e < b_s) ^ la_lt_as ^ (a_e < a_s);
  // The crossing always lies between the endpoints, so no wrap can occur.
  assign b_val      = neg_r ? (b_s - div_rsp.quotient) : (b_s + div_rsp.quotient);

  assign in_accept = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);

  assign q_in_grid = (32'(item_r.query_col) < GRID_COLS) &&
                     (32'(item_r.query_row) < GRID_ROWS);
  assign q_addr    = ADDR_W'(32'(item_r.query_col) * GRID_ROWS + 32'(item_r.query_row));

  assign mk_in_grid = (32'(mk_col) < GRID_COLS) && (32'(mk_row) < GRID_ROWS);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(MAP_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_data.operation == OP_QUERY) ? ST_QRD : ST_SC;
      end
      ST_QRD:  state_nxt = ST_QFIN;
      ST_QFIN: state_nxt = ST_FIN;
      ST_SC: begin
        if (!div_rsp.busy) state_nxt = ST_SR;
      end
      ST_SR: begin
        if (!div_rsp.busy) state_nxt = ST_EC;
      end
      ST_EC: begin
        if (!div_rsp.busy) state_nxt = ST_ER;
      end
      ST_ER: begin
        if (!div_rsp.busy) begin
          state_nxt = (item_r.start_x == item_r.end_x) ? ST_VLO : ST_ALO;
        end
      end
      ST_VLO: begin
        if (!div_rsp.busy) state_nxt = ST_VWALK;
      end
      ST_VWALK: begin
        if (!la_ok) state_nxt = ST_FIN;
      end
      ST_ALO: begin
        if (!div_rsp.busy) state_nxt = ST_ACHK;
      end
      ST_ACHK: begin
        if (la_ok) begin
          state_nxt = ST_ADIV;
        end else if (!pass_r && (item_r.start_y != item_r.end_y)) begin
          state_nxt = ST_ALO;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_ADIV: begin
        if (!div_rsp.busy) state_nxt = ST_BIDX;
      end
      ST_BIDX: begin
        if (!div_rsp.busy) state_nxt = ST_ACHK;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath, divider requests and bitmap accesses
  // --------------------------------------------------------------------------
  always_comb begin
    item_nxt       = item_r;
    col_s_nxt      = col_s_r;
    col_e_nxt      = col_e_r;
    pass_nxt       = pass_r;
    la_nxt         = la_r;
    li_nxt         = li_r;
    neg_nxt        = neg_r;
    res_marked_nxt = res_marked_r;
    res_oog_nxt    = res_oog_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    clr_nxt        = clr_r;
    div_req        = '0;
    mk_en          = 1'b0;
    mk_col         = '0;
    mk_row         = '0;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt       = in_data;
          res_marked_nxt = 1'b0;
          res_oog_nxt    = 1'b0;
          if (in_data.operation == OP_MARK_LINE) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVIDEND_W'(in_data.start_x);
            div_req.divisor  = eff_w;
          end
        end
      end
      ST_QRD: begin
        rd_en = 1'b1;
      end
      ST_QFIN: begin
        res_marked_nxt = q_in_grid && rd_data_r;
        res_oog_nxt    = !q_in_grid;
      end
      ST_SC: begin
        if (!div_rsp.busy) begin
          col_s_nxt        = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = DIVIDEND_W'(item_r.start_y);
          div_req.divisor  = eff_h;
        end
      end
      ST_SR: begin
        if (!div_rsp.busy) begin
          mk_en            = 1'b1;
          mk_col           = {1'b0, col_s_r};
          mk_row           = {1'b0, div_rsp.quotient};
          div_req.start    = 1'b1;
          div_req.dividend = DIVIDEND_W'(item_r.end_x);
          div_req.divisor  = eff_w;
        end
      end
      ST_EC: begin
        if (!div_rsp.busy) begin
          col_e_nxt        = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = DIVIDEND_W'(item_r.end_y);
          div_req.divisor  = eff_h;
        end
      end
      ST_ER: begin
        if (!div_rsp.busy) begin
          mk_en         = 1'b1;
          mk_col        = {1'b0, col_e_r};
          mk_row        = {1'b0, div_rsp.quotient};
          div_req.start = 1'b1;
          if (item_r.start_x == item_r.end_x) begin
            // Vertical segment: walk upwards from the lower endpoint.
            pass_nxt         = 1'b1;
            div_req.dividend = DIVIDEND_W'(min_y);
            div_req.divisor  = eff_h;
          end else begin
            pass_nxt         = 1'b0;
            div_req.dividend = DIVIDEND_W'(min_x);
            div_req.divisor  = eff_w;
          end
        end
      end
      ST_VLO: begin
        // The walk steps by whole tile heights, so its row simply counts up.
        if (!div_rsp.busy) begin
          la_nxt = {1'b0, min_a} + {1'b0, step_a};
          li_nxt = {1'b0, div_rsp.quotient} + 1'b1;
        end
      end
      ST_VWALK: begin
        if (la_ok) begin
          mk_en  = 1'b1;
          mk_col = {1'b0, col_s_r};
          mk_row = li_r;
          la_nxt = la_r + {1'b0, step_a};
          li_nxt = li_r + 1'b1;
        end
      end
      ST_ALO: begin
        // First grid line above the lower end: round down, then one step on.
        if (!div_rsp.busy) begin
          la_nxt = {1'b0, min_a} - {1'b0, div_rsp.remainder} + {1'b0, step_a};
          li_nxt = {1'b0, div_rsp.quotient} + 1'b1;
        end
      end
      ST_ACHK: begin
        if (la_ok) begin
          neg_nxt          = cross_neg;
          div_req.start    = 1'b1;
          div_req.long_op  = 1'b1;
          div_req.dividend = cross_prod;
          div_req.divisor  = a_mag;
        end else if (!pass_r && (item_r.start_y != item_r.end_y)) begin
          pass_nxt         = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = DIVIDEND_W'(min_y);
          div_req.divisor  = eff_h;
        end
      end
      ST_ADIV: begin
        if (!div_rsp.busy) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVIDEND_W'(b_val);
          div_req.divisor  = step_b;
        end
      end
      ST_BIDX: begin
        if (!div_rsp.busy) begin
          mk_en  = 1'b1;
          mk_col = pass_r ? {1'b0, div_rsp.quotient} : li_r;
          mk_row = pass_r ? li_r : {1'b0, div_rsp.quotient};
          la_nxt = la_r + {1'b0, step_a};
          li_nxt = li_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.marked      = res_marked_r;
          out_data_nxt.out_of_grid = res_oog_r;
          out_valid_nxt            = 1'b1;
        end
      end
      default: ;
    endcase

    // A point off the grid is skipped and flagged; otherwise its tile is set.
    if (mk_en) begin
      if (mk_in_grid) begin
        mem_we    = 1'b1;
        mem_waddr = tile_addr(mk_col[COL_W-1:0], mk_row[ROW_W-1:0]);
        mem_wdata = 1'b1;
      end else begin
        res_oog_nxt = 1'b1;
      end
    end
  end

  // Configuration writes are taken at any time.
  always_comb begin
    tile_w_nxt = tile_w_r;
    tile_h_nxt = tile_h_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILE_WIDTH:  tile_w_nxt = cfg_wdata;
        CFG_TILE_HEIGHT: tile_h_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clocked logic
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      tile_w_r    <= TILE_SIZE_RESET;
      tile_h_r    <= TILE_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      tile_w_r    <= tile_w_nxt;
      tile_h_r    <= tile_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    col_s_r      <= col_s_nxt;
    col_e_r      <= col_e_nxt;
    pass_r       <= pass_nxt;
    la_r         <= la_nxt;
    li_r         <= li_nxt;
    neg_r        <= neg_nxt;
    res_marked_r <= res_marked_nxt;
    res_oog_r    <= res_oog_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Bitmap: one write port shared by the clearing pass and marking, and one
  // registered read port for queries.
  always_ff @(posedge clk) begin
    if (mem_we) tile_mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data_r <= tile_mem[q_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
